### rtl/bsbq_pkg.sv
// Shared types and constants for the buffered serial byte queues.
// Holds the request/result structs, operation codes and register layout.
// No dependencies; every other file in rtl refers to it by scoped names.
package bsbq_pkg;

    // Operation codes carried in a request.
    typedef enum logic [1:0] {
        OP_HOST_SEND = 2'd0,
        OP_HOST_RECV = 2'd1,
        OP_TX_READY  = 2'd2,
        OP_LINE_BYTE = 2'd3
    } t_op;

    // Configuration register layout.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;
    localparam int TX_SLOTS_W = 9;
    localparam int RX_SLOTS_W = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_TX_SLOTS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RX_SLOTS = 1'b1;

    localparam logic [TX_SLOTS_W-1:0] TX_SLOTS_RST = 9'd255;
    localparam logic [RX_SLOTS_W-1:0] RX_SLOTS_RST = 6'd20;

    // One request from the host or the line side.
    typedef struct packed {
        t_op        op;
        logic [7:0] data_in;
    } t_req;

    // One result, shown for a single cycle under the strobe.
    typedef struct packed {
        logic       byte_valid;
        logic [7:0] byte_out;
        logic       dropped_oldest;
        logic       tx_active;
    } t_res;

    // Command from the controller to one queue.
    typedef struct packed {
        logic       put;
        logic       get;
        logic [7:0] data;
    } t_q_cmd;

    // Status returned by one queue in the same cycle as its command.
    typedef struct packed {
        logic hit;
        logic dropped;
    } t_q_stat;

endpackage

### rtl/bsbq_queue.sv
// One circular byte queue: a synchronous byte memory plus head and tail pointers.
// Pointers wrap at a clamped slot count; a put into a full queue drops the oldest.
// Depends on bsbq_pkg for the command and status structs.
module bsbq_queue #(
    parameter int DEPTH = 32,
    parameter int REG_W = 6
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [REG_W-1:0]   i_slots,
    input  bsbq_pkg::t_q_cmd   i_cmd,
    output bsbq_pkg::t_q_stat  o_stat,
    output logic [7:0]         o_rdata
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = PW + 1;

    logic [7:0]    r_mem [DEPTH];
    logic [7:0]    r_rdata;
    logic [PW-1:0] r_head;
    logic [PW-1:0] r_tail;
    logic [PW-1:0] n_head;
    logic [PW-1:0] n_tail;

    logic [CW-1:0] eff_slots;
    logic [CW-1:0] head_inc;
    logic [CW-1:0] tail_inc;
    logic [PW-1:0] head_adv;
    logic [PW-1:0] tail_adv;
    logic          not_empty;
    logic          do_read;

    // Clamp the slot register to the range the memory supports.
    always_comb begin
        if (32'(i_slots) < 2) begin
            eff_slots = CW'(2);
        end else if (32'(i_slots) > DEPTH) begin
            eff_slots = CW'(DEPTH);
        end else begin
            eff_slots = CW'(i_slots);
        end
    end

    // Advanced pointers: step by one, back to zero at the slot count or beyond.
    always_comb begin
        head_inc = {1'b0, r_head} + CW'(1);
        tail_inc = {1'b0, r_tail} + CW'(1);
        head_adv = (head_inc >= eff_slots) ? '0 : head_inc[PW-1:0];
        tail_adv = (tail_inc >= eff_slots) ? '0 : tail_inc[PW-1:0];
    end

    assign not_empty = (r_head != r_tail);
    assign do_read   = i_cmd.get && !i_cmd.put && not_empty;

    // Pointer update and status for the current command.
    always_comb begin
        n_head         = r_head;
        n_tail         = r_tail;
        o_stat.hit     = 1'b0;
        o_stat.dropped = 1'b0;
        if (i_cmd.put) begin
            n_head = head_adv;
            if (head_adv == r_tail) begin
                n_tail         = tail_adv;
                o_stat.dropped = 1'b1;
            end
        end else if (do_read) begin
            n_tail     = tail_adv;
            o_stat.hit = 1'b1;
        end
    end

    // Pointer registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
        end
    end

    // Byte memory: write at the head, registered read at the tail.
    always_ff @(posedge i_clk) begin
        if (i_cmd.put) begin
            r_mem[r_head] <= i_cmd.data;
        end
        if (do_read) begin
            r_rdata <= r_mem[r_tail];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/buffered_serial_byte_queues.sv
// Top level of the buffered serial byte queues.
// Holds the slot registers, the transmit enable flag and the result register;
// depends on bsbq_pkg and instantiates bsbq_queue for each direction.
//
// Usage:
//   A request (op, data_in on i_req) is taken at a clock edge where start is
//   high and busy is low. The host sends bytes into the transmit queue, the
//   transmitter pulls them out with a ready request, the line pushes bytes
//   into the receive queue and the host pulls them with a receive request.
//   Each request gives exactly one result on o_res, marked by o_strobe for one
//   cycle, in the cycle right after the request was taken.
//   Latency is one cycle and a new request may be taken every cycle: each
//   queue does one memory access per request, and the registered read port
//   supplies the dequeued byte in the result cycle.
//   The slot counts are written through i_cfg_we, i_cfg_idx and i_cfg_data
//   with no wait; write them only while no result is pending.
//   Synchronous reset empties both queues, sets the transmit enable flag,
//   restores slot counts of 255 (transmit) and 20 (receive) and holds busy
//   high for the reset cycles and the first cycle after reset is released.
//   Results cannot be held off by the receiver.
module buffered_serial_byte_queues #(
    parameter int TX_DEPTH = 256,
    parameter int RX_DEPTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  bsbq_pkg::t_req                    i_req,
    output logic                              o_strobe,
    output bsbq_pkg::t_res                    o_res,
    input  logic                              i_cfg_we,
    input  logic [bsbq_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [bsbq_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    logic [bsbq_pkg::TX_SLOTS_W-1:0] r_tx_slots;
    logic [bsbq_pkg::RX_SLOTS_W-1:0] r_rx_slots;
    logic                            r_busy;
    logic                            r_tx_en;
    logic                            n_tx_en;
    logic                            r_strobe;
    logic                            r_valid;
    logic                            r_from_tx;
    logic                            r_dropped;

    logic              accept;
    bsbq_pkg::t_q_cmd  tx_cmd;
    bsbq_pkg::t_q_cmd  rx_cmd;
    bsbq_pkg::t_q_stat tx_stat;
    bsbq_pkg::t_q_stat rx_stat;
    logic [7:0]        tx_rdata;
    logic [7:0]        rx_rdata;

    assign busy   = r_busy;
    assign accept = start && !r_busy;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_slots <= bsbq_pkg::TX_SLOTS_RST;
            r_rx_slots <= bsbq_pkg::RX_SLOTS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bsbq_pkg::CFG_TX_SLOTS: r_tx_slots <= i_cfg_data;
                bsbq_pkg::CFG_RX_SLOTS:
                    r_rx_slots <= i_cfg_data[bsbq_pkg::RX_SLOTS_W-1:0];
                default: ;
            endcase
        end
    end

    // Decode the request into one command per queue.
    always_comb begin
        tx_cmd.put  = accept && (i_req.op == bsbq_pkg::OP_HOST_SEND);
        tx_cmd.get  = accept && (i_req.op == bsbq_pkg::OP_TX_READY);
        tx_cmd.data = i_req.data_in;
        rx_cmd.put  = accept && (i_req.op == bsbq_pkg::OP_LINE_BYTE);
        rx_cmd.get  = accept && (i_req.op == bsbq_pkg::OP_HOST_RECV);
        rx_cmd.data = i_req.data_in;
    end

    bsbq_queue #(
        .DEPTH (TX_DEPTH),
        .REG_W (bsbq_pkg::TX_SLOTS_W)
    ) u_tx_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_slots (r_tx_slots),
        .i_cmd   (tx_cmd),
        .o_stat  (tx_stat),
        .o_rdata (tx_rdata)
    );

    bsbq_queue #(
        .DEPTH (RX_DEPTH),
        .REG_W (bsbq_pkg::RX_SLOTS_W)
    ) u_rx_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_slots (r_rx_slots),
        .i_cmd   (rx_cmd),
        .o_stat  (rx_stat),
        .o_rdata (rx_rdata)
    );

    // Transmit enable: set by a host send, cleared by a ready on an empty queue.
    always_comb begin
        n_tx_en = r_tx_en;
        if (tx_cmd.put) begin
            n_tx_en = 1'b1;
        end else if (tx_cmd.get && !tx_stat.hit) begin
            n_tx_en = 1'b0;
        end
    end

    // Control state and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b1;
            r_tx_en  <= 1'b1;
            r_strobe <= 1'b0;
        end else begin
            r_busy   <= 1'b0;
            r_tx_en  <= n_tx_en;
            r_strobe <= accept;
        end
    end

    // Result flags; the dequeued byte itself comes from the queue read register.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_valid   <= tx_stat.hit || rx_stat.hit;
            r_from_tx <= tx_cmd.get;
            r_dropped <= tx_stat.dropped || rx_stat.dropped;
        end
    end

    // Result output.
    always_comb begin
        o_res.byte_valid     = r_valid;
        o_res.byte_out       = r_valid ? (r_from_tx ? tx_rdata : rx_rdata) : 8'd0;
        o_res.dropped_oldest = r_dropped;
        o_res.tx_active      = r_tx_en;
    end

    assign o_strobe = r_strobe;

endmodule
